// File: design/nat_pkg.sv
// ----------------------------------------------------------------------------
// nat_pkg
// Shared types and constants for the neighbour ageing table.
// ----------------------------------------------------------------------------
package nat_pkg;

    localparam int ID_W   = 32;
    localparam int LIFE_W = 8;
    localparam int LIVE_W = 6;

    // Transaction opcodes
    localparam logic OP_REFRESH = 1'b0;
    localparam logic OP_SCAN    = 1'b1;

    // Register reset value
    localparam logic [LIFE_W-1:0] MAX_LIFE_RST = 8'd3;

    // Token walking down the row of cells, one cell per cycle
    typedef struct packed {
        logic            vld;
        logic            op;
        logic [ID_W-1:0] id;
        logic            found;     // id already held by an earlier cell
        logic            free_seen; // an earlier cell has reserved its free slot
    } t_tok;

    // Broadcast from the top level when the token leaves the row
    typedef struct packed {
        logic clear;  // drop any slot reservation
        logic commit; // reserved slot becomes a valid entry
    } t_fin;

    // One result transaction
    typedef struct packed {
        logic [LIVE_W-1:0] live_count;
        logic              was_present;
        logic              inserted;
        logic              dropped_full;
    } t_res;

endpackage

// File: design/nat_cell.sv
// ----------------------------------------------------------------------------
// nat_cell
// One table slot: valid bit, id and life, plus one token stage of the row.
// ----------------------------------------------------------------------------
module nat_cell
    import nat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LIFE_W-1:0] i_max_life,
    input  t_tok              i_tok,
    input  t_fin              i_fin,
    output t_tok              o_tok,
    output logic              o_removed,
    output logic              o_cand,
    output logic              o_valid
);

    logic              r_valid;
    logic              r_cand;
    logic [ID_W-1:0]   r_id;
    logic [LIFE_W-1:0] r_life;
    t_tok              r_tok;

    logic n_valid;
    logic n_cand;
    logic [ID_W-1:0]   n_id;
    logic [LIFE_W-1:0] n_life;
    t_tok              n_tok;
    logic              hit;
    logic              take_free;

    // Lookup, slot reservation and ageing while the token sits here
    always_comb begin
        n_valid   = r_valid;
        n_cand    = r_cand;
        n_id      = r_id;
        n_life    = r_life;
        n_tok     = i_tok;
        o_removed = 1'b0;
        hit       = r_valid && (r_id == i_tok.id) && !i_tok.found;
        take_free = !r_valid && !i_tok.free_seen && !i_tok.found;
        if (i_tok.vld) begin
            if (i_tok.op == OP_SCAN) begin
                if (r_valid) begin
                    if (r_life <= LIFE_W'(1)) begin
                        n_valid   = 1'b0;
                        o_removed = 1'b1;
                    end else begin
                        n_life = r_life - LIFE_W'(1);
                    end
                end
            end else begin
                if (hit) begin
                    n_life      = i_max_life;
                    n_tok.found = 1'b1;
                end else if (take_free) begin
                    // id and life are staged now; valid is set on commit
                    n_cand          = 1'b1;
                    n_id            = i_tok.id;
                    n_life          = i_max_life;
                    n_tok.free_seen = 1'b1;
                end
            end
        end
        // End of pass
        if (i_fin.clear) begin
            n_cand = 1'b0;
            if (i_fin.commit && r_cand) begin
                n_valid = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_cand    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_cand    <= n_cand;
            r_tok.vld <= n_tok.vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_id            <= n_id;
        r_life          <= n_life;
        r_tok.op        <= n_tok.op;
        r_tok.id        <= n_tok.id;
        r_tok.found     <= n_tok.found;
        r_tok.free_seen <= n_tok.free_seen;
    end

    assign o_tok   = r_tok;
    assign o_cand  = r_cand;
    assign o_valid = r_valid;

endmodule

// File: design/neighbor_aging_table_core.sv
// A transaction is registered at the row head and in each cell's token stage,
// then its result is written to the result queue. The lookup token walks the
// row of cells one slot per cycle and one item is in the row at once.
// A two-entry result queue lets the next transaction in while a result waits.
// Reset (synchronous, active low) empties the table; max_life returns to 3.
// ----------------------------------------------------------------------------
// neighbor_aging_table_core
// Soft-state neighbour table with per-entry time-to-live ageing.
// ----------------------------------------------------------------------------
module neighbor_aging_table_core
    import nat_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [LIFE_W-1:0] i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_node_id,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [LIVE_W-1:0] o_live_count,
    output logic              o_was_present,
    output logic              o_inserted,
    output logic              o_dropped_full
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [LIFE_W-1:0] r_max_life;
    logic              r_busy;
    t_tok              r_tok_head;
    logic [CNT_W-1:0]  r_count;
    t_res              r_q0;
    t_res              r_q1;
    logic [1:0]        r_q_cnt;

    t_tok                   tok [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] removed;
    logic [TABLE_DEPTH-1:0] cand;
    logic [TABLE_DEPTH-1:0] valid_vec;
    t_fin                   fin;
    t_tok                   tok_exit;
    logic                   accept;
    logic                   pop;
    logic                   commit;
    logic [CNT_W-1:0]       n_count;
    t_res                   res_new;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_life <= MAX_LIFE_RST;
        end else if (i_cfg_we) begin
            r_max_life <= i_cfg_data;
        end
    end

    // Handshakes
    assign o_in_ready = !r_busy && (r_q_cnt != 2'd2);
    assign accept     = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;

    // Row of cells
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            nat_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_max_life (r_max_life),
                .i_tok      (r_tok_head),
                .i_fin      (fin),
                .o_tok      (tok[gi]),
                .o_removed  (removed[gi]),
                .o_cand     (cand[gi]),
                .o_valid    (valid_vec[gi])
            );
        end else begin : g_rest
            nat_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_max_life (r_max_life),
                .i_tok      (tok[gi-1]),
                .i_fin      (fin),
                .o_tok      (tok[gi]),
                .o_removed  (removed[gi]),
                .o_cand     (cand[gi]),
                .o_valid    (valid_vec[gi])
            );
        end
    end

    assign tok_exit = tok[TABLE_DEPTH-1];

    // End-of-pass decision
    assign commit     = tok_exit.vld && (tok_exit.op == OP_REFRESH)
                        && !tok_exit.found && tok_exit.free_seen;
    assign fin.clear  = tok_exit.vld;
    assign fin.commit = commit;

    // Live count: removals arrive one per cycle, insertion at exit
    always_comb begin
        n_count = r_count;
        if (|removed) begin
            n_count = r_count - CNT_W'(1);
        end else if (commit) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        res_new.live_count   = LIVE_W'(n_count);
        res_new.was_present  = (tok_exit.op == OP_REFRESH) && tok_exit.found;
        res_new.inserted     = commit;
        res_new.dropped_full = (tok_exit.op == OP_REFRESH) && !tok_exit.found
                               && !tok_exit.free_seen;
    end

    // Token injection, busy flag and live count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_tok_head.vld <= 1'b0;
            r_count        <= '0;
        end else begin
            r_tok_head.vld <= accept;
            r_count        <= n_count;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tok_exit.vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tok_head.op        <= i_opcode;
            r_tok_head.id        <= i_node_id;
            r_tok_head.found     <= 1'b0;
            r_tok_head.free_seen <= 1'b0;
        end
    end

    // Two-entry result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            case ({tok_exit.vld, pop})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({tok_exit.vld, pop})
            2'b10: begin
                if (r_q_cnt == 2'd0) begin
                    r_q0 <= res_new;
                end else begin
                    r_q1 <= res_new;
                end
            end
            2'b01: begin
                r_q0 <= r_q1;
            end
            2'b11: begin
                if (r_q_cnt == 2'd1) begin
                    r_q0 <= res_new;
                end else begin
                    r_q0 <= r_q1;
                    r_q1 <= res_new;
                end
            end
            default: begin
                r_q0 <= r_q0;
            end
        endcase
    end

    assign o_out_valid    = (r_q_cnt != 2'd0);
    assign o_live_count   = r_q0.live_count;
    assign o_was_present  = r_q0.was_present;
    assign o_inserted     = r_q0.inserted;
    assign o_dropped_full = r_q0.dropped_full;

    // Checks
    a_one_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cand))
        else $error("more than one slot reserved");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_count == CNT_W'($countones(valid_vec))))
        else $error("live count disagrees with valid entries");

    a_exit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_exit.vld |=> !r_busy)
        else $error("busy held after token left the row");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_exit.vld |-> (r_q_cnt != 2'd2))
        else $error("result queue overflow");

endmodule
